// ===== design/dtf_pkg.sv =====
// shared types and constants for the decimal text to float parser
package dtf_pkg;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // 53-bit double significands and unbiased exponents of the scale factors
  localparam logic [52:0] SIG_P01 = 53'h147AE147AE147B;
  localparam logic [52:0] SIG_P1  = 53'h1999999999999A;
  localparam logic [52:0] SIG_T10 = 53'h14000000000000;
  localparam logic signed [9:0] EXP_P01 = -10'sd7;
  localparam logic signed [9:0] EXP_P1  = -10'sd4;
  localparam logic signed [9:0] EXP_T10 = 10'sd3;

  localparam logic [31:0] FLOAT_INF = 32'h7F800000;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    SC_P01,
    SC_P1,
    SC_T10
  } scale_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_NORM,
    ST_ROUND0,
    ST_DECIDE,
    ST_MLO,
    ST_MHI,
    ST_ADD,
    ST_R53,
    ST_R24,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic   load_norm;
    logic   shift_norm;
    logic   round_init;
    logic   pick;
    scale_t sel;
    logic   mul_lo;
    logic   mul_hi;
    logic   add;
    logic   r53;
    logic   r24;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic is_term;
    logic norm_top;
    logic man_zero;
    logic e_le_m2;
    logic e_neg;
    logic e_pos;
    logic inf;
    logic out_free;
  } status_t;

endpackage

// ===== design/dtf_if.sv =====
// request channels: characters in, parse results out
interface dtf_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       start_req;
  modport source (output valid, char_in, start_req, input ready);
  modport sink (input valid, char_in, start_req, output ready);
endinterface

interface dtf_res_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] value_bits;
  logic [7:0]  chars_used;
  modport source (output valid, ok, value_bits, chars_used, input ready);
  modport sink (input valid, ok, value_bits, chars_used, output ready);
endinterface

// ===== design/dtf_datapath.sv =====
// parse registers, float scaling unit and result register
module dtf_datapath #(
  parameter int MAX_DIGITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [7:0]      char_in,
  input  logic            start_req,
  input  dtf_pkg::cmd_t   cmd,
  output dtf_pkg::status_t status,
  input  logic            out_ready,
  output logic            out_valid,
  output logic            out_ok,
  output logic [31:0]     out_bits,
  output logic [7:0]      out_chars
);
  import dtf_pkg::*;

  localparam int MW  = $clog2(10 ** MAX_DIGITS);
  localparam int DCW = $clog2(MAX_DIGITS + 2);
  localparam logic [DCW-1:0] MAXD = DCW'(MAX_DIGITS);

  phase_t          phase;
  logic            negative;
  logic [MW-1:0]   mantissa;
  logic signed [7:0] dec_exponent;
  logic [DCW-1:0]  digit_count;
  logic            point_seen;
  logic [7:0]      char_count;

  phase_t          phase_next;
  logic            negative_next;
  logic [MW-1:0]   mantissa_next;
  logic signed [7:0] dec_exponent_next;
  logic [DCW-1:0]  digit_count_next;
  logic            point_seen_next;
  logic [7:0]      char_count_next;
  logic            term;

  logic [MW-1:0]   norm;
  logic signed [9:0] fe;
  logic [23:0]     fm;
  logic signed [7:0] ework;
  logic            inf;
  scale_t          sel;
  logic [50:0]     plo;
  logic [49:0]     phi;
  logic [76:0]     prod;
  logic [52:0]     q53;
  logic signed [9:0] e53;

  always_comb begin
    logic [7:0] d;
    logic [MW+3:0] m10;
    phase_next        = start_req ? PH_FIRST : phase;
    negative_next     = start_req ? 1'b0 : negative;
    mantissa_next     = start_req ? '0 : mantissa;
    dec_exponent_next = start_req ? 8'sd0 : dec_exponent;
    digit_count_next  = start_req ? '0 : digit_count;
    point_seen_next   = start_req ? 1'b0 : point_seen;
    char_count_next   = start_req ? 8'd0 : char_count;
    term = 1'b0;
    d = char_in - CH_ZERO;
    m10 = '0;
    if (phase_next == PH_DONE) begin
      term = 1'b0;
    end else if (phase_next == PH_FIRST && (char_in == CH_MINUS || char_in == CH_PLUS)) begin
      phase_next = PH_BODY;
      negative_next = (char_in == CH_MINUS);
      if (char_count_next != 8'd255) char_count_next = char_count_next + 8'd1;
    end else begin
      phase_next = PH_BODY;
      if (d <= 8'd9) begin
        if (digit_count_next <= MAXD) digit_count_next = digit_count_next + DCW'(1);
        if (digit_count_next <= MAXD) begin
          if (point_seen_next) dec_exponent_next = dec_exponent_next - 8'sd1;
          m10 = ({4'b0, mantissa_next} << 3) + ({4'b0, mantissa_next} << 1)
                + (MW+4)'(d);
          mantissa_next = m10[MW-1:0];
        end else if (!point_seen_next && dec_exponent_next < 8'sd127) begin
          dec_exponent_next = dec_exponent_next + 8'sd1;
        end
        if (char_count_next != 8'd255) char_count_next = char_count_next + 8'd1;
      end else if (char_in == CH_POINT && !point_seen_next) begin
        point_seen_next = 1'b1;
        if (char_count_next != 8'd255) char_count_next = char_count_next + 8'd1;
      end else begin
        phase_next = PH_DONE;
        term = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FIRST;
      negative     <= 1'b0;
      mantissa     <= '0;
      dec_exponent <= 8'sd0;
      digit_count  <= '0;
      point_seen   <= 1'b0;
      char_count   <= 8'd0;
    end else if (fire) begin
      phase        <= phase_next;
      negative     <= negative_next;
      mantissa     <= mantissa_next;
      dec_exponent <= dec_exponent_next;
      digit_count  <= digit_count_next;
      point_seen   <= point_seen_next;
      char_count   <= char_count_next;
    end
  end

  // scale factor selection
  logic [52:0]       sig;
  logic signed [9:0] cexp;
  always_comb begin
    unique case (sel)
      SC_P01:  begin sig = SIG_P01; cexp = EXP_P01; end
      SC_P1:   begin sig = SIG_P1;  cexp = EXP_P1;  end
      SC_T10:  begin sig = SIG_T10; cexp = EXP_T10; end
      default: begin sig = SIG_T10; cexp = EXP_T10; end
    endcase
  end

  // initial rounding of the integer mantissa to 24 bits
  logic [31:0] n32;
  logic [24:0] r0;
  assign n32 = {norm, {(32-MW){1'b0}}};
  assign r0 = {1'b0, n32[31:8]} + 25'(n32[7] & ((|n32[6:0]) | n32[8]));

  // product rounded to double
  logic        pt;
  logic [52:0] q;
  logic        pg, ps;
  logic [53:0] qr;
  assign pt = prod[76];
  assign q  = pt ? prod[76:24] : prod[75:23];
  assign pg = pt ? prod[23] : prod[22];
  assign ps = pt ? (|prod[22:0]) : (|prod[21:0]);
  assign qr = {1'b0, q} + 54'(pg & (ps | q[0]));

  // double rounded to single
  logic [24:0]       r1;
  logic signed [9:0] fe1;
  assign r1  = {1'b0, q53[52:29]} + 25'(q53[28] & ((|q53[27:0]) | q53[29]));
  assign fe1 = r1[24] ? e53 + 10'sd1 : e53;

  always_ff @(posedge clk) begin
    if (cmd.load_norm) begin
      norm  <= mantissa;
      fe    <= 10'(MW - 1);
      ework <= dec_exponent;
      inf   <= 1'b0;
    end
    if (cmd.shift_norm) begin
      norm <= norm << 1;
      fe   <= fe - 10'sd1;
    end
    if (cmd.round_init) begin
      fm <= r0[24] ? r0[24:1] : r0[23:0];
      if (r0[24]) fe <= fe + 10'sd1;
    end
    if (cmd.pick) sel <= cmd.sel;
    if (cmd.mul_lo) plo <= fm * sig[26:0];
    if (cmd.mul_hi) phi <= fm * sig[52:27];
    if (cmd.add) prod <= {phi, 27'b0} + 77'(plo);
    if (cmd.r53) begin
      q53 <= qr[53] ? qr[53:1] : qr[52:0];
      e53 <= fe + cexp + 10'(pt) + 10'(qr[53]);
    end
    if (cmd.r24) begin
      fm <= r1[24] ? r1[24:1] : r1[23:0];
      fe <= fe1;
      if (fe1 > 10'sd127) inf <= 1'b1;
      unique case (sel)
        SC_P01:  ework <= ework + 8'sd2;
        SC_P1:   ework <= ework + 8'sd1;
        SC_T10:  ework <= ework - 8'sd1;
        default: ework <= ework;
      endcase
    end
  end

  logic [9:0]  biased;
  logic [31:0] mag;
  assign biased = fe + 10'sd127;
  assign mag = inf ? FLOAT_INF : (mantissa == '0) ? 32'd0 : {1'b0, biased[7:0], fm[22:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ok    <= (digit_count != '0);
      out_bits  <= (digit_count != '0) ? (mag ^ {negative, 31'b0}) : 32'd0;
      out_chars <= (digit_count != '0) ? char_count : 8'd0;
    end
  end

  assign status.is_term  = term;
  assign status.norm_top = norm[MW-1];
  assign status.man_zero = (mantissa == '0);
  assign status.e_le_m2  = (ework <= -8'sd2);
  assign status.e_neg    = (ework < 8'sd0);
  assign status.e_pos    = (ework > 8'sd0);
  assign status.inf      = inf;
  assign status.out_free = !out_valid || out_ready;

endmodule

// ===== design/dtf_ctrl.sv =====
// sequencer for parsing, normalization and the scaling steps
module dtf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  dtf_pkg::status_t status,
  output dtf_pkg::cmd_t    cmd,
  output logic             ready
);
  import dtf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (fire && status.is_term) state_next = ST_INIT;
      ST_INIT:   state_next = status.man_zero ? ST_FINISH : ST_NORM;
      ST_NORM:   if (status.norm_top) state_next = ST_ROUND0;
      ST_ROUND0: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (status.e_neg || (status.e_pos && !status.inf)) state_next = ST_MLO;
        else state_next = ST_FINISH;
      end
      ST_MLO:    state_next = ST_MHI;
      ST_MHI:    state_next = ST_ADD;
      ST_ADD:    state_next = ST_R53;
      ST_R53:    state_next = ST_R24;
      ST_R24:    state_next = ST_DECIDE;
      ST_FINISH: if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.sel = SC_T10;
    ready = (state == ST_IDLE);
    unique case (state)
      ST_INIT:   cmd.load_norm = 1'b1;
      ST_NORM:   cmd.shift_norm = !status.norm_top;
      ST_ROUND0: cmd.round_init = 1'b1;
      ST_DECIDE: begin
        cmd.pick = 1'b1;
        priority if (status.e_le_m2) cmd.sel = SC_P01;
        else if (status.e_neg)       cmd.sel = SC_P1;
        else                         cmd.sel = SC_T10;
      end
      ST_MLO:    cmd.mul_lo = 1'b1;
      ST_MHI:    cmd.mul_hi = 1'b1;
      ST_ADD:    cmd.add = 1'b1;
      ST_R53:    cmd.r53 = 1'b1;
      ST_R24:    cmd.r24 = 1'b1;
      ST_FINISH: cmd.load_out = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ===== design/decimal_text_to_float_parser.sv =====
// top level: ascii decimal text to single-precision float
// a non-terminating character is taken while ready is high, and ready stays high
// a terminator holds ready low through INIT, then, for a nonzero mantissa, NORM, ROUND0
// and DECIDE, MLO, MHI, ADD, R53, R24 per scaling step (24x53 multiply in two passes),
// then FINISH; results sit in an output register; characters are taken while a result waits
// reset (rst, synchronous): parser awaits a first character, no result pending
module decimal_text_to_float_parser #(
  parameter int MAX_DIGITS = 8
) (
  input logic     clk,
  input logic     rst,
  dtf_char_if.sink  chars,
  dtf_res_if.source results
);
  import dtf_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    rdy;
  logic    fire;

  assign chars.ready = rdy;
  assign fire = chars.valid && rdy;

  dtf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .status (status),
    .cmd    (cmd),
    .ready  (rdy)
  );

  dtf_datapath #(.MAX_DIGITS(MAX_DIGITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .char_in   (chars.char_in),
    .start_req (chars.start_req),
    .cmd       (cmd),
    .status    (status),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .out_ok    (results.ok),
    .out_bits  (results.value_bits),
    .out_chars (results.chars_used)
  );

endmodule

// ===== design/dtf_checker.sv =====
// port-level checks on the parser result channel, bound to the top level
module dtf_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_ok,
  input logic [31:0] res_bits,
  input logic [7:0]  res_chars
);

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ok |-> res_bits == 32'd0 && res_chars == 8'd0)
    else $error("failed parse carries nonzero payload");

  a_ok_chars: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ok |-> res_chars != 8'd0)
    else $error("good parse with no characters used");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_bits) && $stable(res_chars))
    else $error("stalled result changed");

endmodule

bind decimal_text_to_float_parser dtf_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_ok    (results.ok),
  .res_bits  (results.value_bits),
  .res_chars (results.chars_used)
);

// ===== sim/tb_decimal_text_to_float_parser.sv =====
// testbench for the decimal text to float parser: random and directed text, self-checking
module tb_decimal_text_to_float_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import dtf_pkg::*;

  localparam int MAX_DIGITS = 8;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 1000;

  typedef struct {
    logic [7:0] ch;
    logic       start;
  } char_req_t;

  typedef struct {
    logic        ok;
    logic [31:0] value_bits;
    logic [7:0]  chars_used;
  } parse_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dtf_char_if chars_if();
  dtf_res_if  res_if();

  decimal_text_to_float_parser #(.MAX_DIGITS(MAX_DIGITS)) uut (
    .clk(clk),
    .rst(rst),
    .chars(chars_if),
    .results(res_if)
  );

  always #5 clk = ~clk;

  char_req_t  pending_chars[$];
  parse_res_t expected_results[$];
  int         failures = 0;
  int         idle_cycles = 0;
  bit         stim_done = 1'b0;

  // parser state mirror
  phase_t      p_phase = PH_FIRST;
  bit          p_negative = 1'b0;
  int unsigned p_mantissa = 0;
  int          p_exponent = 0;
  int unsigned p_digits = 0;
  bit          p_point = 1'b0;
  int unsigned p_count = 0;

  // double bit pattern to single, round to nearest even (normal range only)
  function automatic logic [31:0] to_single(real r);
    logic [63:0] d;
    logic [31:0] f;
    logic [28:0] rest;
    d = $realtobits(r);
    if (d[62:0] == 63'd0) return {d[63], 31'd0};
    f = {d[63], 8'(int'(d[62:52]) - 1023 + 127), d[51:29]};
    rest = d[28:0];
    if (rest > 29'h10000000 || (rest == 29'h10000000 && f[0])) f = f + 32'd1;
    return f;
  endfunction

  function automatic logic [31:0] float_value(int unsigned man, int ex, bit neg);
    real fv;
    real d;
    real inf_edge;
    bit  inf;
    logic [31:0] bits;
    inf_edge = $bitstoreal(64'h47EFFFFFF0000000);
    inf = 1'b0;
    fv = $bitstoreal({to_single(real'(man)), 29'd0} == 0 ? 64'd0 : 64'd0);
    bits = to_single(real'(man));
    fv = $bitstoreal({bits[31], bits[30:23] == 0 ? 11'd0 : 11'(int'(bits[30:23]) - 127 + 1023),
                      bits[22:0], 29'd0});
    if (man != 0) begin
      while (ex <= -2) begin
        bits = to_single(fv * 0.01);
        fv = $bitstoreal({bits[31], 11'(int'(bits[30:23]) - 127 + 1023), bits[22:0], 29'd0});
        ex += 2;
      end
      if (ex < 0) begin
        bits = to_single(fv * 0.1);
      end else begin
        while (ex > 0 && !inf) begin
          d = fv * 10.0;
          if (d >= inf_edge) begin
            inf = 1'b1;
          end else begin
            bits = to_single(d);
            fv = $bitstoreal({bits[31], 11'(int'(bits[30:23]) - 127 + 1023), bits[22:0],
                              29'd0});
          end
          ex--;
        end
      end
    end
    if (inf) bits = FLOAT_INF;
    if (neg) bits[31] = ~bits[31];
    return bits;
  endfunction

  task automatic parse_char(logic [7:0] c, logic s);
    parse_res_t r;
    logic [7:0] d;
    if (s) begin
      p_phase = PH_FIRST; p_negative = 0; p_mantissa = 0; p_exponent = 0;
      p_digits = 0; p_point = 0; p_count = 0;
    end
    if (p_phase == PH_DONE) return;
    if (p_phase == PH_FIRST) begin
      p_phase = PH_BODY;
      if (c == CH_MINUS || c == CH_PLUS) begin
        p_negative = (c == CH_MINUS);
        if (p_count < 255) p_count++;
        return;
      end
    end
    d = c - CH_ZERO;
    if (d <= 9) begin
      if (p_digits <= MAX_DIGITS) p_digits++;
      if (p_digits <= MAX_DIGITS) begin
        if (p_point) p_exponent--;
        p_mantissa = p_mantissa * 10 + d;
      end else if (!p_point && p_exponent < 127) begin
        p_exponent++;
      end
      if (p_count < 255) p_count++;
      return;
    end
    if (c == CH_POINT && !p_point) begin
      p_point = 1'b1;
      if (p_count < 255) p_count++;
      return;
    end
    p_phase = PH_DONE;
    if (p_digits == 0) begin
      r = '{1'b0, 32'd0, 8'd0};
    end else begin
      r.ok = 1'b1;
      r.value_bits = float_value(p_mantissa, p_exponent, p_negative);
      r.chars_used = 8'(p_count);
    end
    expected_results.push_back(r);
  endtask

  function automatic void add_char(logic [7:0] c, logic s);
    pending_chars.push_back('{c, s});
  endfunction

  function automatic void add_text(string t);
    for (int i = 0; i < t.len(); i++) add_char(t[i], i == 0);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_term();
    case ($urandom_range(0, 5))
      0: return 8'h20;
      1: return 8'h0A;
      2: return CH_POINT;
      3: return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one random number text (it may hold no digits), then a terminator or random byte and optional noise
  function automatic void add_number();
    int n_int;
    int n_frac;
    bit first;
    first = 1'b1;
    n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 6);
    n_frac = $urandom_range(0, 9);
    if ($urandom_range(0, 2) == 0) begin
      add_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, 1'b1);
      first = 1'b0;
    end
    for (int i = 0; i < n_int; i++) begin
      add_char($urandom_range(0, 4) == 0 ? CH_ZERO : rand_digit(), first);
      first = 1'b0;
    end
    if ($urandom_range(0, 1)) begin
      add_char(CH_POINT, first);
      first = 1'b0;
      for (int i = 0; i < n_frac; i++) add_char(rand_digit(), 1'b0);
    end
    add_char(rand_term(), first);
    repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3))
      add_char(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  // stimulus
  initial begin
    string big;
    add_text("0 ");
    add_text("99999999\n");
    add_text("-0 ");
    add_text("+12.5x");
    add_text("- ");
    add_text("+");
    add_char(8'h00, 1'b0);
    add_text("x");
    add_text(".");
    add_text("1-");
    add_text("3.14.15");
    add_text(".00000001 ");
    add_text("123456789012.987,");
    add_text("0.00000000001 ");
    big = "1";
    for (int i = 0; i < 140; i++) big = {big, "9"};
    add_text({big, " "});
    big = "-0.";
    for (int i = 0; i < 300; i++) big = {big, "0"};
    add_text({big, "1 "});
    add_char(8'hFF, 1'b1);
    add_char(8'hFF, 1'b0);
    while (pending_chars.size() < 1350) begin
      if ($urandom_range(0, 7) == 0) add_char(8'($urandom_range(0, 255)), $urandom_range(0, 1));
      else add_number();
    end
    stim_done = 1'b1;
  end

  // character driver
  int  send_gap = 0;
  bit  send_burst = 1'b0;
  always @(posedge clk) begin
    char_req_t it;
    if (rst) begin
      chars_if.valid <= 1'b0;
      chars_if.char_in <= 8'd0;
      chars_if.start_req <= 1'b0;
    end else if (chars_if.valid && !chars_if.ready) begin
      // hold the request
    end else if (send_gap > 0) begin
      chars_if.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_chars.size() > 0) begin
      it = pending_chars.pop_front();
      chars_if.char_in <= it.ch;
      chars_if.start_req <= it.start;
      chars_if.valid <= 1'b1;
      if ($urandom_range(0, 31) == 0) send_burst <= ~send_burst;
      send_gap <= send_burst ? 0 : $urandom_range(0, 11);
    end else begin
      chars_if.valid <= 1'b0;
    end
  end

  // result monitor and checker
  int recv_stall = 0;
  always @(posedge clk) begin
    parse_res_t e;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (chars_if.valid && chars_if.ready) parse_char(chars_if.char_in, chars_if.start_req);
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result ok=%0d value_bits=%h", res_if.ok, res_if.value_bits);
          failures++;
        end else begin
          e = expected_results.pop_front();
          if (res_if.ok !== e.ok) begin
            $error("ok: expected %0d actual %0d", e.ok, res_if.ok);
            failures++;
          end
          if (res_if.value_bits !== e.value_bits) begin
            $error("value_bits: expected %h actual %h", e.value_bits, res_if.value_bits);
            failures++;
          end
          if (res_if.chars_used !== e.chars_used) begin
            $error("chars_used: expected %0d actual %0d", e.chars_used, res_if.chars_used);
            failures++;
          end
        end
      end
      if (recv_stall > 0) begin
        res_if.ready <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else begin
        res_if.ready <= 1'b1;
        if (res_if.valid && res_if.ready)
          recv_stall <= send_burst ? 0 : $urandom_range(0, 11);
      end
      if ((chars_if.valid && chars_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    chars_if.valid = 1'b0;
    chars_if.char_in = 8'd0;
    chars_if.start_req = 1'b0;
    res_if.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done);
    while (pending_chars.size() > 0 || chars_if.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/dtf_pkg.sv
design/dtf_if.sv
design/dtf_datapath.sv
design/dtf_ctrl.sv
design/decimal_text_to_float_parser.sv
design/dtf_checker.sv
sim/tb_decimal_text_to_float_parser.sv
